/* design/icd_pkg.sv */
// Shared constants for the Creutz-demon Ising spin update core.
package icd_pkg;

  localparam int unsigned SITES         = 1024;
  localparam int unsigned SITE_W        = $clog2(SITES);
  localparam int unsigned MAX_NEIGHBORS = 8;
  localparam int unsigned NB_IDX_W      = $clog2(MAX_NEIGHBORS);
  localparam int unsigned NB_CNT_W      = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned DEMON_W       = 16;

  // Input item layout in tdata, lowest bit first.
  localparam int unsigned IN_SITE_LSB = 0;
  localparam int unsigned IN_DVAL_LSB = IN_SITE_LSB + 10;
  localparam int unsigned IN_CNT_LSB  = IN_DVAL_LSB + 16;
  localparam int unsigned IN_CNT_W    = 4;
  localparam int unsigned IN_NB_LSB   = IN_CNT_LSB + IN_CNT_W;
  localparam int unsigned IN_NB_W     = 10;
  localparam int unsigned IN_BITS     = IN_NB_LSB + 8 * IN_NB_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Result item layout in tdata, lowest bit first.
  localparam int unsigned OUT_BITS    = 10 + 1 + 1 + 16;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Command codes carried in tuser.
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

endpackage

/* design/ising_creutz_demon_spin_update.sv */
// Spin and demon storage with its read-modify-write sequencer.
module icd_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           in_cmd_i,
  input  logic [icd_pkg::IN_TDATA_W-1:0] in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [icd_pkg::OUT_TDATA_W-1:0] out_data_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NEIGH,
    ST_SELF
  } state_e;

  state_e state_q;

  logic [icd_pkg::SITE_W-1:0]   clr_addr_q;
  logic                         cmd_q;
  logic [icd_pkg::SITE_W-1:0]   site_q;
  logic [icd_pkg::DEMON_W-1:0]  dval_q;
  logic [icd_pkg::NB_CNT_W-1:0] cnt_q;
  logic [icd_pkg::SITE_W-1:0]   nb_q [icd_pkg::MAX_NEIGHBORS];
  logic [icd_pkg::NB_CNT_W-1:0] idx_q;
  logic [icd_pkg::NB_CNT_W-1:0] pos_q;
  logic                         nb_pend_q;
  logic                         out_valid_q;
  logic [icd_pkg::OUT_TDATA_W-1:0] out_data_q;

  // Storage ports
  logic                         spin_mem [icd_pkg::SITES];
  logic [icd_pkg::DEMON_W-1:0]  demon_mem [icd_pkg::SITES];
  logic                         spin_re, spin_we, spin_wdata, spin_rdata_q;
  logic [icd_pkg::SITE_W-1:0]   spin_addr;
  logic                         demon_re, demon_we;
  logic [icd_pkg::SITE_W-1:0]   demon_addr;
  logic [icd_pkg::DEMON_W-1:0]  demon_wdata, demon_rdata_q;

  logic                         accept;
  logic                         out_free;
  logic                         nb_issue;
  logic [icd_pkg::IN_CNT_W-1:0] cnt_raw;
  logic [icd_pkg::NB_CNT_W-1:0] cnt_sat;

  logic signed [5:0]            sum_w;
  logic signed [6:0]            de2_w, de_w, de_abs;
  logic [4:0]                   mag_w;
  logic                         de_le0;
  logic [icd_pkg::DEMON_W:0]    gain_w;
  logic                         flip_w;
  logic                         spin_new;
  logic [icd_pkg::DEMON_W-1:0]  demon_new;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign nb_issue    = (state_q == ST_NEIGH) && (cmd_q == icd_pkg::CMD_UPDATE) &&
                       (idx_q < cnt_q);

  assign cnt_raw = in_data_i[icd_pkg::IN_CNT_LSB +: icd_pkg::IN_CNT_W];
  assign cnt_sat = (cnt_raw > icd_pkg::IN_CNT_W'(icd_pkg::MAX_NEIGHBORS)) ?
                   icd_pkg::NB_CNT_W'(icd_pkg::MAX_NEIGHBORS) :
                   icd_pkg::NB_CNT_W'(cnt_raw);

  // Energy change: sum = 2*pos - cnt, dE = 2 * self * sum
  always_comb begin
    sum_w  = $signed({1'b0, pos_q, 1'b0}) - $signed({2'b00, cnt_q});
    de2_w  = {sum_w, 1'b0};
    de_w   = spin_rdata_q ? de2_w : -de2_w;
    de_le0 = de_w[6] || (de_w == 7'sd0);
    de_abs = de_w[6] ? -de_w : de_w;
    mag_w  = de_abs[4:0];
    gain_w = {1'b0, demon_rdata_q} + (icd_pkg::DEMON_W + 1)'(mag_w);
    flip_w = (cmd_q == icd_pkg::CMD_UPDATE) &&
             (de_le0 || (demon_rdata_q >= icd_pkg::DEMON_W'(mag_w)));
    spin_new = flip_w ? ~spin_rdata_q : spin_rdata_q;
    if (cmd_q == icd_pkg::CMD_WRITE) begin
      demon_new = dval_q;
    end else if (de_le0) begin
      demon_new = gain_w[icd_pkg::DEMON_W] ? '1 : gain_w[icd_pkg::DEMON_W-1:0];
    end else if (flip_w) begin
      demon_new = demon_rdata_q - icd_pkg::DEMON_W'(mag_w);
    end else begin
      demon_new = demon_rdata_q;
    end
  end

  // Memory port control
  always_comb begin
    spin_re     = 1'b0;
    spin_we     = 1'b0;
    spin_addr   = site_q;
    spin_wdata  = spin_new;
    demon_re    = 1'b0;
    demon_we    = 1'b0;
    demon_addr  = site_q;
    demon_wdata = demon_new;
    case (state_q)
      ST_CLEAR: begin
        spin_we     = 1'b1;
        demon_we    = 1'b1;
        spin_addr   = clr_addr_q;
        demon_addr  = clr_addr_q;
        spin_wdata  = 1'b1;
        demon_wdata = '0;
      end
      ST_NEIGH: begin
        spin_re = 1'b1;
        if (nb_issue) begin
          spin_addr = nb_q[idx_q[icd_pkg::NB_IDX_W-1:0]];
        end else begin
          demon_re = 1'b1;
        end
      end
      ST_SELF: begin
        spin_we  = out_free;
        demon_we = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (spin_we) begin
      spin_mem[spin_addr] <= spin_wdata;
    end
    if (spin_re) begin
      spin_rdata_q <= spin_mem[spin_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (demon_we) begin
      demon_mem[demon_addr] <= demon_wdata;
    end
    if (demon_re) begin
      demon_rdata_q <= demon_mem[demon_addr];
    end
  end

  // Latch the item fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd_i;
      site_q <= in_data_i[icd_pkg::IN_SITE_LSB +: icd_pkg::SITE_W];
      dval_q <= in_data_i[icd_pkg::IN_DVAL_LSB +: icd_pkg::DEMON_W];
      cnt_q  <= cnt_sat;
      for (int k = 0; k < icd_pkg::MAX_NEIGHBORS; k++) begin
        nb_q[k] <= in_data_i[icd_pkg::IN_NB_LSB + k * icd_pkg::IN_NB_W +: icd_pkg::SITE_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      nb_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      nb_pend_q <= nb_issue;
      if (nb_pend_q) begin
        pos_q <= pos_q + icd_pkg::NB_CNT_W'(spin_rdata_q);
      end
      if (state_q == ST_SELF && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == icd_pkg::SITE_W'(icd_pkg::SITES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            idx_q   <= '0;
            pos_q   <= '0;
            state_q <= ST_NEIGH;
          end
        end
        ST_NEIGH: begin
          if (nb_issue) begin
            idx_q <= idx_q + 1'b1;
          end else begin
            state_q <= ST_SELF;
          end
        end
        ST_SELF: begin
          // hold until the output register is free
          if (out_free) begin
            out_data_q  <= icd_pkg::OUT_TDATA_W'({demon_new, flip_w, spin_new, site_q});
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(spin_we && spin_re) && !(demon_we && demon_re))
    else $error("memory read and write in the same cycle");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEIGH) |-> (idx_q <= cnt_q) && (pos_q <= idx_q))
    else $error("neighbor index ran past count");

  a_demon_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SELF && demon_we && cmd_q == icd_pkg::CMD_UPDATE && !flip_w)
    |-> (demon_wdata == demon_rdata_q))
    else $error("demon changed without a flip");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o && !out_valid_o)
    else $error("item traffic during clearing pass");

endmodule

/* design/ising_creutz_demon_spin_update_core.sv */
// Top level of the Creutz-demon Ising spin update core.
// After reset the core sweeps both stores (spins to +1, demons to zero) and takes no
// item until that pass ends. An update item reads neighbor_count neighbors (the count
// saturated at 8), a demon write reads none: one single-port spin memory serves one
// neighbor read per cycle, then the site's spin and demon are read together and written back
// with the new values. A finished result waits in an output register, so the next item is
// taken while it is still pending; a stalled output only delays the final write-back.
module ising_creutz_demon_spin_update_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // site[9:0], demon_value[25:10], neighbor_count[29:26], neighbor_0..7[109:30], zero pad
  input  logic [icd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // site_out[9:0], spin_out[10], flipped[11], demon_out[27:12], zero pad
  output logic [icd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  icd_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
